[src/text_console_cursor_scroll_core_macros.svh]
// Assertion macros for the console cursor and scroll core.
// Included by the RTL files that carry assertions; no dependencies.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define TCCS_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
    else $error("tccs assertion failed");

// consequent in the same cycle as the antecedent
`define TCCS_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("tccs assertion failed");

// consequent in the cycle after the antecedent
`define TCCS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("tccs assertion failed");

`else

`define TCCS_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr)
`define TCCS_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)
`define TCCS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

[src/tccs_pkg.sv]
// Shared widths, codes and types of the console cursor and scroll core.
// No dependencies; used by the channel interfaces and all modules.
package tccs_pkg;

  localparam int ADDR_W   = 14;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int FC_W     = 13;
  localparam int CON_W    = 2;
  localparam int CFG_W    = 13;

  localparam int DEF_LINE_CELLS   = 80;
  localparam int DEF_SCREEN_CELLS = 2000;
  localparam int DEF_CONSOLES     = 3;
  localparam int DEF_VIDEO_WORDS  = 16384;

  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
  localparam logic [COLOR_W-1:0] RST_COLOR    = 8'd7;

  typedef enum logic {
    ACT_PUT    = 1'b0,
    ACT_SELECT = 1'b1
  } action_t;

  typedef enum logic {
    CFG_CHAR_COLOR   = 1'b0,
    CFG_FIRST_CURSOR = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  cursor_pos;
    logic [ADDR_W-1:0]  display_start;
    logic               cell_write;
    logic [ADDR_W-1:0]  cell_addr;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
  } result_t;

endpackage

[src/tccs_in_if.sv]
// Request channel of the console core: action, console and character.
// Depends on tccs_pkg.
interface tccs_in_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CON_W-1:0]  console;
  logic [CHAR_W-1:0] character;

  modport source (output valid, action, console, character, input ready);
  modport sink   (input valid, action, console, character, output ready);
endinterface

[src/tccs_out_if.sv]
// Result channel of the console core: cursor, display start, cell write.
// Depends on tccs_pkg.
interface tccs_out_if import tccs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  cursor_pos;
  logic [ADDR_W-1:0]  display_start;
  logic               cell_write;
  logic [ADDR_W-1:0]  cell_addr;
  logic [CHAR_W-1:0]  cell_char;
  logic [COLOR_W-1:0] cell_color;

  modport source (output valid, cursor_pos, display_start, cell_write, cell_addr,
                  cell_char, cell_color, input ready);
  modport sink   (input valid, cursor_pos, display_start, cell_write, cell_addr,
                  cell_char, cell_color, output ready);
endinterface

[src/text_console_cursor_scroll_core.sv]
// An accepted request is registered in the b stage, then written to the result queue.
// Throughput: one request per cycle while no first_cursor column is being found and
// the result queue has room; per-console cursor and scroll memories are read, then
// written back, with one-deep forwarding between neighbors.
// Reset: control clears at once; entries never written read as the console origin.
`include "text_console_cursor_scroll_core_macros.svh"
module text_console_cursor_scroll_core import tccs_pkg::*; #(
  parameter int LINE_CELLS   = DEF_LINE_CELLS,
  parameter int SCREEN_CELLS = DEF_SCREEN_CELLS,
  parameter int CONSOLES     = DEF_CONSOLES,
  parameter int VIDEO_WORDS  = DEF_VIDEO_WORDS
) (
  input  logic             clk,
  input  logic             rst_n,
  tccs_in_if.sink          in_if,
  tccs_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int REGION = LINE_CELLS * (VIDEO_WORDS / CONSOLES / LINE_CELLS);
  localparam int IDX_W  = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
  localparam int LINE_W = $clog2(LINE_CELLS);
  localparam int EW     = ADDR_W + 1;
  localparam int QDEPTH = 3;
  localparam int QP_W   = 2;
  localparam int CW     = ADDR_W + LINE_W;

  // configuration
  logic [COLOR_W-1:0] char_color_r;
  logic [FC_W-1:0]    fc_r;
  logic               fc_start;
  logic               col_busy;
  logic               col_done;
  logic [LINE_W-1:0]  fc_col;

  always_comb begin
    fc_start = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CHAR_COLOR:   fc_start = 1'b0;
        CFG_FIRST_CURSOR: fc_start = 1'b1;
        default:          fc_start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_color_r <= RST_COLOR;
      fc_r         <= '0;
    end else if (cfg_we) begin
      if (fc_start) begin
        fc_r <= cfg_wdata[FC_W-1:0];
      end else begin
        char_color_r <= cfg_wdata[COLOR_W-1:0];
      end
    end
  end

  tccs_col_unit #(.LINE_CELLS(LINE_CELLS)) u_col (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fc_start),
    .value (cfg_wdata[FC_W-1:0]),
    .busy  (col_busy),
    .done  (col_done),
    .col   (fc_col)
  );

  // request side
  logic             in_acc;
  logic             in_range;
  logic [IDX_W-1:0] rd_idx;
  logic [QP_W:0]    q_cnt_r;
  logic             b_valid_r;

  assign in_range    = (CON_W + 1)'(in_if.console) < (CON_W + 1)'(CONSOLES);
  assign in_if.ready = !col_busy && (({1'b0, q_cnt_r} + (QP_W + 2)'(b_valid_r)) <
                                     (QP_W + 2)'(QDEPTH));
  assign in_acc      = in_if.valid && in_if.ready;
  assign rd_idx      = in_range ? in_if.console[IDX_W-1:0] : '0;

  // state memories: {cursor, column} and scroll start
  logic [CW-1:0]     cur_mem [CONSOLES];
  logic [ADDR_W-1:0] scr_mem [CONSOLES];
  logic [CONSOLES-1:0] cvld_r;
  logic [CONSOLES-1:0] svld_r;
  logic [CW-1:0]     cur_rd_r;
  logic [ADDR_W-1:0] scr_rd_r;
  logic              cvld_rd_r;
  logic              svld_rd_r;

  logic              b_action_r;
  logic [IDX_W-1:0]  b_idx_r;
  logic [CHAR_W-1:0] b_char_r;

  logic              fwd_valid_r;
  logic [IDX_W-1:0]  fwd_idx_r;
  logic [ADDR_W-1:0] fwd_c_r;
  logic [LINE_W-1:0] fwd_col_r;
  logic [ADDR_W-1:0] fwd_s_r;

  logic              wr_b;
  logic [ADDR_W-1:0] c0;
  logic [ADDR_W-1:0] s0;
  logic [LINE_W-1:0] col0;
  logic [EW-1:0]     org;
  logic [EW-1:0]     lim;
  logic [EW-1:0]     c1;
  logic [EW-1:0]     s_mid;
  logic [EW-1:0]     s1;
  logic [EW-1:0]     shown;
  logic [LINE_W-1:0] col1;
  logic [LINE_W-1:0] col_inc;
  logic [LINE_W-1:0] col_dec;
  logic [ADDR_W-1:0] c2;
  logic [ADDR_W-1:0] s2;
  logic              wr_cell;
  logic [ADDR_W-1:0] w_addr;
  logic [CHAR_W-1:0] w_char;
  result_t           b_res;

  always_ff @(posedge clk) begin
    cur_rd_r  <= cur_mem[rd_idx];
    scr_rd_r  <= scr_mem[rd_idx];
    cvld_rd_r <= cvld_r[rd_idx];
    svld_rd_r <= svld_r[rd_idx];
    if (wr_b) begin
      cur_mem[b_idx_r] <= {c2, col1};
      scr_mem[b_idx_r] <= s2;
    end else if (col_done) begin
      cur_mem[0] <= {ADDR_W'(fc_r), fc_col};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
      svld_r <= '0;
    end else if (wr_b) begin
      cvld_r[b_idx_r] <= 1'b1;
      svld_r[b_idx_r] <= 1'b1;
    end else if (col_done) begin
      cvld_r[0] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= in_acc && in_range;
      fwd_valid_r <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    b_action_r <= in_if.action;
    b_idx_r    <= rd_idx;
    b_char_r   <= in_if.character;
    fwd_idx_r  <= b_idx_r;
    fwd_c_r    <= c2;
    fwd_col_r  <= col1;
    fwd_s_r    <= s2;
  end

  assign wr_b = b_valid_r && (action_t'(b_action_r) == ACT_PUT);
  assign org  = EW'(b_idx_r) * EW'(REGION);
  assign lim  = org + EW'(REGION);

  // take the previous cycle's write over the stale memory read
  always_comb begin
    if (fwd_valid_r && (fwd_idx_r == b_idx_r)) begin
      c0   = fwd_c_r;
      col0 = fwd_col_r;
      s0   = fwd_s_r;
    end else begin
      c0   = cvld_rd_r ? cur_rd_r[CW-1:LINE_W] : org[ADDR_W-1:0];
      col0 = cvld_rd_r ? cur_rd_r[LINE_W-1:0] : '0;
      s0   = svld_rd_r ? scr_rd_r : org[ADDR_W-1:0];
    end
  end

  assign col_inc = (col0 == LINE_W'(LINE_CELLS - 1)) ? '0 : col0 + 1'b1;
  assign col_dec = (col0 == '0) ? LINE_W'(LINE_CELLS - 1) : col0 - 1'b1;

  always_comb begin
    c1      = {1'b0, c0};
    col1    = col0;
    wr_cell = 1'b0;
    w_addr  = '0;
    w_char  = '0;
    case (b_char_r)
      CH_NEWLINE: begin
        if (({1'b0, c0} >= org) && (({1'b0, c0} + EW'(LINE_CELLS)) < lim)) begin
          c1   = {1'b0, c0} - EW'(col0) + EW'(LINE_CELLS);
          col1 = '0;
        end
      end
      CH_BACKSPACE: begin
        if ({1'b0, c0} > org) begin
          c1      = {1'b0, c0} - 1'b1;
          col1    = col_dec;
          wr_cell = 1'b1;
          w_addr  = c0 - 1'b1;
          w_char  = CH_SPACE;
        end
      end
      default: begin
        if ({1'b0, c0} < lim) begin
          c1      = {1'b0, c0} + 1'b1;
          col1    = col_inc;
          wr_cell = 1'b1;
          w_addr  = c0;
          w_char  = b_char_r;
        end
      end
    endcase

    // scroll one line back, then one line forward
    s_mid = {1'b0, s0};
    if ((c1 < s_mid) && (s_mid > org)) begin
      s_mid = s_mid - EW'(LINE_CELLS);
    end
    s1 = s_mid;
    if ((c1 >= s_mid + EW'(SCREEN_CELLS)) && ((s_mid + EW'(SCREEN_CELLS)) < lim) &&
        (c1 > (EW'(LINE_CELLS) + org))) begin
      s1 = s_mid + EW'(LINE_CELLS);
    end
    c2 = c1[ADDR_W-1:0];
    s2 = s1[ADDR_W-1:0];

    if (c2 < s2) begin
      shown = {1'b0, c2} - EW'(col1);
    end else if ({1'b0, c2} > ({1'b0, s2} + EW'(SCREEN_CELLS))) begin
      shown = {1'b0, c2} - EW'(col1) + EW'(LINE_CELLS) - EW'(SCREEN_CELLS);
    end else begin
      shown = {1'b0, s2};
    end

    if (action_t'(b_action_r) == ACT_SELECT) begin
      b_res.cursor_pos    = c0;
      b_res.display_start = s0;
      b_res.cell_write    = 1'b0;
      b_res.cell_addr     = '0;
      b_res.cell_char     = '0;
      b_res.cell_color    = '0;
    end else begin
      b_res.cursor_pos    = c2;
      b_res.display_start = shown[ADDR_W-1:0];
      b_res.cell_write    = wr_cell;
      b_res.cell_addr     = w_addr;
      b_res.cell_char     = w_char;
      b_res.cell_color    = wr_cell ? char_color_r : '0;
    end
  end

  // result queue
  result_t         q_mem_r [QDEPTH];
  logic [QP_W-1:0] q_head_r;
  logic [QP_W-1:0] q_tail_r;
  logic            q_pop;
  result_t         q_out;

  assign q_pop = out_if.valid && out_if.ready;
  assign q_out = q_mem_r[q_head_r];

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      q_mem_r[q_tail_r] <= b_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (b_valid_r) begin
        q_tail_r <= (q_tail_r == QP_W'(QDEPTH - 1)) ? '0 : q_tail_r + 1'b1;
      end
      if (q_pop) begin
        q_head_r <= (q_head_r == QP_W'(QDEPTH - 1)) ? '0 : q_head_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + (QP_W + 1)'(b_valid_r) - (QP_W + 1)'(q_pop);
    end
  end

  assign out_if.valid         = q_cnt_r != '0;
  assign out_if.cursor_pos    = q_out.cursor_pos;
  assign out_if.display_start = q_out.display_start;
  assign out_if.cell_write    = q_out.cell_write;
  assign out_if.cell_addr     = q_out.cell_addr;
  assign out_if.cell_char     = q_out.cell_char;
  assign out_if.cell_color    = q_out.cell_color;

  `TCCS_ASSERT_ALWAYS(a_queue_room, clk, rst_n,
    ({1'b0, q_cnt_r} + (QP_W + 2)'(b_valid_r)) <= (QP_W + 2)'(QDEPTH))
  `TCCS_ASSERT_NEXT(a_fwd_follows_write, clk, rst_n, wr_b,
    fwd_valid_r && (fwd_idx_r == $past(b_idx_r)))
  `TCCS_ASSERT_IMPLIES(a_col_bound, clk, rst_n, wr_b,
    ({1'b0, col1} < (LINE_W + 1)'(LINE_CELLS)))
  `TCCS_ASSERT_IMPLIES(a_idle_fields_zero, clk, rst_n, out_if.valid && !out_if.cell_write,
    (out_if.cell_addr == '0) && (out_if.cell_char == '0) && (out_if.cell_color == '0))

endmodule

[src/tccs_col_unit.sv]
// Column of a loaded cursor by reciprocal multiplication: the value is registered, then the quotient.
// Depends on tccs_pkg.
module tccs_col_unit import tccs_pkg::*; #(
  parameter int LINE_CELLS = DEF_LINE_CELLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [FC_W-1:0]               value,
  output logic                          busy,
  output logic                          done,
  output logic [$clog2(LINE_CELLS)-1:0] col
);

  localparam int LINE_W = $clog2(LINE_CELLS);
  localparam int SH     = FC_W + LINE_W;
  localparam int MW     = FC_W + 1;
  localparam int PW     = FC_W + MW;
  localparam int QW     = PW - SH;
  // rounded-up reciprocal; exact quotient for every FC_W-bit value
  localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + LINE_CELLS - 1) / LINE_CELLS);

  logic            run_r;
  logic            done_r;
  logic [FC_W-1:0] val_r;
  logic [QW-1:0]   quo_r;
  logic [PW-1:0]   prod;
  logic [FC_W-1:0] rem;

  assign prod = PW'(val_r) * PW'(RECIP);
  assign rem  = val_r - FC_W'(quo_r) * FC_W'(LINE_CELLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      val_r  <= value;
    end else if (run_r) begin
      run_r  <= 1'b0;
      done_r <= 1'b1;
      quo_r  <= prod[PW-1:SH];
    end else begin
      done_r <= 1'b0;
    end
  end

  assign busy = run_r || done_r;
  assign done = done_r;
  assign col  = rem[LINE_W-1:0];

endmodule
